FILE: design/tep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timed event queue.
// No dependencies; imported by tep_cell and timed_event_priority_queue.
package tep_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int TIME_BITS_DEF = 48;
    localparam int ID_BITS_DEF   = 32;
    localparam int CNT_BITS      = 6;
    localparam int LIMIT_BITS    = 17;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'd100000;

    typedef enum logic [2:0] {
        OP_SCHED_AT    = 3'd0,
        OP_SCHED_AFTER = 3'd1,
        OP_CANCEL      = 3'd2,
        OP_RUN_UNTIL   = 3'd3,
        OP_ADVANCE_BY  = 3'd4,
        OP_CLEAR       = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PAST      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_FULL      = 3'd4,
        ST_BACKWARDS = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_RESP = 3'b100
    } t_state;

    // One command per cycle, broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
        logic pop;
        logic clear;
    } t_cell_cmd;

endpackage

FILE: design/tep_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted event chain: holds time, id and valid, and trades
// entries with its neighbors on insert, remove and pop. Uses tep_pkg.
module tep_cell #(
    parameter int TIME_BITS = tep_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = tep_pkg::ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tep_pkg::t_cell_cmd    i_cmd,
    input  logic [TIME_BITS-1:0]  i_new_time,
    input  logic [ID_BITS-1:0]    i_new_id,
    input  logic [ID_BITS-1:0]    i_target_id,
    input  logic                  i_left_valid,
    input  logic [TIME_BITS-1:0]  i_left_time,
    input  logic [ID_BITS-1:0]    i_left_id,
    input  logic                  i_left_ins,
    input  logic                  i_left_rm,
    input  logic                  i_right_valid,
    input  logic [TIME_BITS-1:0]  i_right_time,
    input  logic [ID_BITS-1:0]    i_right_id,
    output logic                  o_valid,
    output logic [TIME_BITS-1:0]  o_time,
    output logic [ID_BITS-1:0]    o_id,
    output logic                  o_ins,
    output logic                  o_rm
);
    import tep_pkg::*;

    logic                 r_valid, n_valid;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [ID_BITS-1:0]   r_id, n_id;

    // New ids are always the largest live id, so only time decides order.
    assign o_ins = !r_valid || (i_new_time < r_time);
    // Set at the matching cell and everything behind it.
    assign o_rm  = i_left_rm || (r_valid && (r_id == i_target_id));

    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_id    = r_id;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.pop || (i_cmd.remove && o_rm)) begin
            n_valid = i_right_valid;
            n_time  = i_right_time;
            n_id    = i_right_id;
        end else if (i_cmd.insert && o_ins) begin
            if (i_left_ins) begin
                n_valid = i_left_valid;
                n_time  = i_left_time;
                n_id    = i_left_id;
            end else begin
                n_valid = 1'b1;
                n_time  = i_new_time;
                n_id    = i_new_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_time <= n_time;
        r_id   <= n_id;
    end

    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_id    = r_id;

endmodule

FILE: design/timed_event_priority_queue.sv
`timescale 1ns / 1ps
// Timed event queue top level: command decode, run sequencer, result register.
// Depends on tep_pkg and tep_cell.

// Pending events live in a chain of CAPACITY cells kept sorted by due time,
// then id, so the earliest event always sits in the first cell. For schedule,
// cancel, clear and unknown opcodes the chain is updated at the transfer edge
// and the acknowledge is loaded into the result register from S_RESP. A
// run that is not rejected passes through S_RUN and S_RESP once for each fired
// event and once for the final run-finished result; each step examines the head
// cell, popping it if it fires, then loads the result register. A stalled
// output holds back the step that waits on it. Results wait in the output
// register while the next item is accepted. No clearing pass after reset.
module timed_event_priority_queue #(
    parameter int CAPACITY  = tep_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = tep_pkg::TIME_BITS_DEF,
    parameter int ID_BITS   = tep_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tep_pkg::LIMIT_BITS-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_opcode,
    input  logic [TIME_BITS-1:0]          i_time_value,
    input  logic [ID_BITS-1:0]            i_target_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [2:0]                    o_status,
    output logic [ID_BITS-1:0]            o_event_id,
    output logic [TIME_BITS-1:0]          o_event_time,
    output logic                          o_limit_hit,
    output logic [tep_pkg::CNT_BITS-1:0]  o_pending_count,
    output logic                          o_has_next,
    output logic [TIME_BITS-1:0]          o_next_due,
    output logic                          o_last
);
    import tep_pkg::*;

    // control and run state
    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_cur, n_cur;
    logic [ID_BITS-1:0]    r_next_id, n_next_id;
    logic [CNT_BITS-1:0]   r_live, n_live;
    logic [LIMIT_BITS-1:0] r_limit;
    logic [TIME_BITS-1:0]  r_deadline, n_deadline;
    logic [LIMIT_BITS-1:0] r_cnt, n_cnt;
    logic [TIME_BITS-1:0]  r_ctime, n_ctime;

    // chain wiring
    logic [CAPACITY-1:0]  w_valid;
    logic [TIME_BITS-1:0] w_time [CAPACITY];
    logic [ID_BITS-1:0]   w_id   [CAPACITY];
    logic [CAPACITY-1:0]  w_ins;
    logic [CAPACITY-1:0]  w_rm;
    t_cell_cmd            c_cmd;
    logic [TIME_BITS-1:0] c_new_time;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                 l_valid, rgt_valid;
            logic [TIME_BITS-1:0] l_time, rgt_time;
            logic [ID_BITS-1:0]   l_id, rgt_id;
            logic                 l_ins, l_rm;
            if (gi == 0) begin : g_head
                assign l_valid = 1'b0;
                assign l_time  = '0;
                assign l_id    = '0;
                assign l_ins   = 1'b0;
                assign l_rm    = 1'b0;
            end else begin : g_mid
                assign l_valid = w_valid[gi-1];
                assign l_time  = w_time[gi-1];
                assign l_id    = w_id[gi-1];
                assign l_ins   = w_ins[gi-1];
                assign l_rm    = w_rm[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign rgt_valid = 1'b0;
                assign rgt_time  = '0;
                assign rgt_id    = '0;
            end else begin : g_body
                assign rgt_valid = w_valid[gi+1];
                assign rgt_time  = w_time[gi+1];
                assign rgt_id    = w_id[gi+1];
            end
            tep_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (c_cmd),
                .i_new_time    (c_new_time),
                .i_new_id      (r_next_id),
                .i_target_id   (i_target_id),
                .i_left_valid  (l_valid),
                .i_left_time   (l_time),
                .i_left_id     (l_id),
                .i_left_ins    (l_ins),
                .i_left_rm     (l_rm),
                .i_right_valid (rgt_valid),
                .i_right_time  (rgt_time),
                .i_right_id    (rgt_id),
                .o_valid       (w_valid[gi]),
                .o_time        (w_time[gi]),
                .o_id          (w_id[gi]),
                .o_ins         (w_ins[gi]),
                .o_rm          (w_rm[gi])
            );
        end
    endgenerate

    // pending result
    t_kind                 r_res_kind, n_res_kind;
    t_status               r_res_status, n_res_status;
    logic [ID_BITS-1:0]    r_res_id, n_res_id;
    logic [TIME_BITS-1:0]  r_res_time, n_res_time;
    logic                  r_res_lim, n_res_lim;
    logic                  r_res_last, n_res_last;

    logic                  r_out_valid;
    logic                  c_accept, c_out_free, c_load;
    logic [TIME_BITS:0]    c_sum;
    logic [TIME_BITS-1:0]  c_at;
    logic                  c_found;
    logic [LIMIT_BITS-1:0] c_eff_cnt;

    assign c_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign c_out_free = !r_out_valid || !i_out_stall;
    assign c_load     = (r_state == S_RESP) && c_out_free;
    assign c_sum      = {1'b0, r_cur} + {1'b0, i_time_value};
    assign c_at       = (i_opcode == OP_SCHED_AT) ? i_time_value : c_sum[TIME_BITS-1:0];
    assign c_found    = w_rm[CAPACITY-1] && (i_target_id != '0);
    assign c_new_time = c_at;
    assign c_eff_cnt  = ((r_cnt != '0) && (w_time[0] == r_ctime)) ? r_cnt : '0;

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_next_id    = r_next_id;
        n_live       = r_live;
        n_deadline   = r_deadline;
        n_cnt        = r_cnt;
        n_ctime      = r_ctime;
        n_res_kind   = r_res_kind;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_time   = r_res_time;
        n_res_lim    = r_res_lim;
        n_res_last   = r_res_last;
        c_cmd        = '0;

        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_state      = S_RESP;
                    n_res_kind   = KIND_ACK;
                    n_res_status = ST_OK;
                    n_res_id     = '0;
                    n_res_time   = '0;
                    n_res_lim    = 1'b0;
                    n_res_last   = 1'b1;
                    case (i_opcode)
                        OP_SCHED_AT, OP_SCHED_AFTER: begin
                            if (i_opcode == OP_SCHED_AFTER && c_sum[TIME_BITS]) begin
                                n_res_status = ST_OVERFLOW;
                            end else if (c_at < r_cur) begin
                                n_res_status = ST_PAST;
                            end else if (r_next_id == '0) begin
                                n_res_status = ST_EXHAUSTED;
                            end else if (r_live == CNT_BITS'(CAPACITY)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                c_cmd.insert = 1'b1;
                                n_res_id     = r_next_id;
                                n_res_time   = c_at;
                                n_next_id    = r_next_id + 1'b1;
                                n_live       = r_live + 1'b1;
                            end
                        end
                        OP_CANCEL: begin
                            if (c_found) begin
                                c_cmd.remove = 1'b1;
                                n_live       = r_live - 1'b1;
                            end else begin
                                n_res_status = ST_NOT_FOUND;
                            end
                        end
                        OP_RUN_UNTIL, OP_ADVANCE_BY: begin
                            n_res_kind = KIND_DONE;
                            n_res_time = r_cur;
                            if (i_opcode == OP_RUN_UNTIL && i_time_value < r_cur) begin
                                n_res_status = ST_BACKWARDS;
                            end else if (i_opcode == OP_ADVANCE_BY && c_sum[TIME_BITS]) begin
                                n_res_status = ST_OVERFLOW;
                            end else begin
                                n_state    = S_RUN;
                                n_cnt      = '0;
                                n_deadline = (i_opcode == OP_RUN_UNTIL) ?
                                             i_time_value : c_sum[TIME_BITS-1:0];
                            end
                        end
                        OP_CLEAR: begin
                            c_cmd.clear = 1'b1;
                            n_live      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_state      = S_RESP;
                n_res_status = ST_OK;
                n_res_lim    = 1'b0;
                if (!w_valid[0] || (w_time[0] > r_deadline)) begin
                    n_cur      = r_deadline;
                    n_res_kind = KIND_DONE;
                    n_res_id   = '0;
                    n_res_time = r_deadline;
                    n_res_last = 1'b1;
                end else if (c_eff_cnt >= r_limit) begin
                    // head stays pending; time stops at its due time
                    n_cur      = w_time[0];
                    n_res_kind = KIND_DONE;
                    n_res_id   = '0;
                    n_res_time = w_time[0];
                    n_res_lim  = 1'b1;
                    n_res_last = 1'b1;
                end else begin
                    c_cmd.pop  = 1'b1;
                    n_live     = r_live - 1'b1;
                    n_cur      = w_time[0];
                    n_ctime    = w_time[0];
                    n_cnt      = c_eff_cnt + 1'b1;
                    n_res_kind = KIND_FIRE;
                    n_res_id   = w_id[0];
                    n_res_time = w_time[0];
                    n_res_last = 1'b0;
                end
            end
            S_RESP: begin
                if (c_out_free) begin
                    n_state = r_res_last ? S_IDLE : S_RUN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_next_id   <= ID_BITS'(1);
            r_live      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_next_id <= n_next_id;
            r_live    <= n_live;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (c_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_deadline   <= n_deadline;
        r_cnt        <= n_cnt;
        r_ctime      <= n_ctime;
        r_res_kind   <= n_res_kind;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_time   <= n_res_time;
        r_res_lim    <= n_res_lim;
        r_res_last   <= n_res_last;
        if (c_load) begin
            o_kind          <= r_res_kind;
            o_status        <= r_res_status;
            o_event_id      <= r_res_id;
            o_event_time    <= r_res_time;
            o_limit_hit     <= r_res_lim;
            o_last          <= r_res_last;
            o_pending_count <= r_live;
            o_has_next      <= w_valid[0];
            o_next_due      <= w_valid[0] ? w_time[0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    // live entries are packed at the head of the chain
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & CAPACITY'(w_valid + 1'b1)) == '0)
        else $error("chain has a hole");

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_live))
        else $error("live count disagrees with chain");

    a_fire_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_kind == KIND_FIRE) |-> (o_event_time <= r_cur))
        else $error("fired event ahead of current time");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_last) |-> (r_state != S_IDLE))
        else $error("idle while a run is unfinished");

endmodule

FILE: tb/tb_timed_event_priority_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed event queue: directed and random commands,
// random stalls on both channels, every result checked against a scoreboard.
// Depends on tep_pkg and timed_event_priority_queue.

import tep_pkg::*;

typedef struct packed {
    logic [1:0]               kind;
    logic [2:0]               status;
    logic [ID_BITS_DEF-1:0]   event_id;
    logic [TIME_BITS_DEF-1:0] event_time;
    logic                     limit_hit;
    logic [CNT_BITS-1:0]      pending;
    logic                     has_next;
    logic [TIME_BITS_DEF-1:0] next_due;
    logic                     last;
} t_reply;

class tep_scoreboard;
    logic [TIME_BITS_DEF-1:0] slot_time [CAPACITY_DEF];
    logic [ID_BITS_DEF-1:0]   slot_id   [CAPACITY_DEF];
    bit                       slot_live [CAPACITY_DEF];
    logic [TIME_BITS_DEF-1:0] now_time;
    logic [TIME_BITS_DEF-1:0] time_max;
    logic [ID_BITS_DEF-1:0]   id_next;
    int unsigned              live;
    int unsigned              fire_limit;
    t_reply                   replies[$];
    int                       errors;

    function new();
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        now_time   = '0;
        time_max   = '1;
        id_next    = 1;
        live       = 0;
        fire_limit = LIMIT_RESET;
        errors     = 0;
    endfunction

    // Earliest live event by time, then id; -1 when empty.
    function int head_slot();
        int best;
        best = -1;
        for (int i = 0; i < CAPACITY_DEF; i++) begin
            if (slot_live[i] && (best < 0 || slot_time[i] < slot_time[best] ||
                (slot_time[i] == slot_time[best] && slot_id[i] < slot_id[best])))
                best = i;
        end
        return best;
    endfunction

    function void push_reply(t_kind kind, t_status status, logic [ID_BITS_DEF-1:0] id,
                             logic [TIME_BITS_DEF-1:0] at, bit lim, bit last);
        t_reply r;
        int     b;
        b            = head_slot();
        r.kind       = kind;
        r.status     = status;
        r.event_id   = id;
        r.event_time = at;
        r.limit_hit  = lim;
        r.pending    = CNT_BITS'(live);
        r.has_next   = (b >= 0);
        r.next_due   = (b >= 0) ? slot_time[b] : '0;
        r.last       = last;
        replies.push_back(r);
    endfunction

    function void insert_event(logic [TIME_BITS_DEF-1:0] at);
        int s;
        if (at < now_time) begin
            push_reply(KIND_ACK, ST_PAST, '0, '0, 0, 1);
        end else if (id_next == 0) begin
            push_reply(KIND_ACK, ST_EXHAUSTED, '0, '0, 0, 1);
        end else if (live >= CAPACITY_DEF) begin
            push_reply(KIND_ACK, ST_FULL, '0, '0, 0, 1);
        end else begin
            s = 0;
            while (slot_live[s]) s++;
            slot_time[s] = at;
            slot_id[s]   = id_next;
            slot_live[s] = 1'b1;
            live++;
            push_reply(KIND_ACK, ST_OK, id_next, at, 0, 1);
            id_next = id_next + 1;
        end
    endfunction

    function void fire_until(logic [TIME_BITS_DEF-1:0] deadline);
        logic [TIME_BITS_DEF-1:0] group_time;
        int unsigned              group_n;
        int                       b;
        bit                       done;
        group_time = '0;
        group_n    = 0;
        done       = 1'b0;
        while (!done) begin
            b = head_slot();
            if (b < 0 || slot_time[b] > deadline) begin
                now_time = deadline;
                push_reply(KIND_DONE, ST_OK, '0, deadline, 0, 1);
                done = 1'b1;
            end else begin
                if (group_n == 0 || slot_time[b] != group_time) begin
                    group_time = slot_time[b];
                    group_n    = 0;
                end
                if (group_n >= fire_limit) begin
                    // the event over the limit stays queued
                    now_time = slot_time[b];
                    push_reply(KIND_DONE, ST_OK, '0, slot_time[b], 1, 1);
                    done = 1'b1;
                end else begin
                    slot_live[b] = 1'b0;
                    live--;
                    now_time = slot_time[b];
                    group_n++;
                    push_reply(KIND_FIRE, ST_OK, slot_id[b], slot_time[b], 0, 0);
                end
            end
        end
    endfunction

    function void accept_command(logic [2:0] op, logic [TIME_BITS_DEF-1:0] tv,
                                 logic [ID_BITS_DEF-1:0] tid);
        int hit;
        hit = -1;
        case (op)
            OP_SCHED_AT: insert_event(tv);
            OP_SCHED_AFTER: begin
                if (tv > time_max - now_time)
                    push_reply(KIND_ACK, ST_OVERFLOW, '0, '0, 0, 1);
                else
                    insert_event(now_time + tv);
            end
            OP_CANCEL: begin
                if (tid != 0) begin
                    for (int i = 0; i < CAPACITY_DEF; i++)
                        if (slot_live[i] && slot_id[i] == tid) hit = i;
                end
                if (hit >= 0) begin
                    slot_live[hit] = 1'b0;
                    live--;
                    push_reply(KIND_ACK, ST_OK, '0, '0, 0, 1);
                end else begin
                    push_reply(KIND_ACK, ST_NOT_FOUND, '0, '0, 0, 1);
                end
            end
            OP_RUN_UNTIL: begin
                if (tv < now_time)
                    push_reply(KIND_DONE, ST_BACKWARDS, '0, now_time, 0, 1);
                else
                    fire_until(tv);
            end
            OP_ADVANCE_BY: begin
                if (tv > time_max - now_time)
                    push_reply(KIND_DONE, ST_OVERFLOW, '0, now_time, 0, 1);
                else
                    fire_until(now_time + tv);
            end
            OP_CLEAR: begin
                foreach (slot_live[i]) slot_live[i] = 1'b0;
                live = 0;
                push_reply(KIND_ACK, ST_OK, '0, '0, 0, 1);
            end
            default: push_reply(KIND_ACK, ST_OK, '0, '0, 0, 1);
        endcase
    endfunction

    function logic [ID_BITS_DEF-1:0] pick_live_id();
        int idx[$];
        for (int i = 0; i < CAPACITY_DEF; i++)
            if (slot_live[i]) idx.push_back(i);
        if (idx.size() == 0) return '0;
        return slot_id[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_reply(t_reply got);
        t_reply want;
        if (replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected result kind %0h id %0h time %0h", $time,
                     got.kind, got.event_id, got.event_time);
            return;
        end
        want = replies.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("status", want.status, got.status);
        compare_field("event_id", want.event_id, got.event_id);
        compare_field("event_time", want.event_time, got.event_time);
        compare_field("limit_hit", want.limit_hit, got.limit_hit);
        compare_field("pending_count", want.pending, got.pending);
        compare_field("has_next", want.has_next, got.has_next);
        compare_field("next_due", want.next_due, got.next_due);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module tb_timed_event_priority_queue;
    // Slowest legal run is far below this; it only catches a hang.
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;
    localparam logic [TIME_BITS_DEF-1:0] TIME_MAX = '1;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [LIMIT_BITS-1:0]     i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [2:0]                i_opcode;
    logic [TIME_BITS_DEF-1:0]  i_time_value;
    logic [ID_BITS_DEF-1:0]    i_target_id;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_kind;
    logic [2:0]                o_status;
    logic [ID_BITS_DEF-1:0]    o_event_id;
    logic [TIME_BITS_DEF-1:0]  o_event_time;
    logic                      o_limit_hit;
    logic [CNT_BITS-1:0]       o_pending_count;
    logic                      o_has_next;
    logic [TIME_BITS_DEF-1:0]  o_next_due;
    logic                      o_last;

    tep_scoreboard sb;
    bit            idling_on   = 1'b1;
    int            hold_seq    = 0;
    int            hold_seen   = 0;
    int            rx_left     = 0;
    bit            rx_stalled  = 1'b0;
    int            cycle_count = 0;

    timed_event_priority_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_time_value    (i_time_value),
        .i_target_id     (i_target_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_event_id      (o_event_id),
        .o_event_time    (o_event_time),
        .o_limit_hit     (o_limit_hit),
        .o_pending_count (o_pending_count),
        .o_has_next      (o_has_next),
        .o_next_due      (o_next_due),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed_event_priority_queue: mismatch");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.kind       = o_kind;
            got.status     = o_status;
            got.event_id   = o_event_id;
            got.event_time = o_event_time;
            got.limit_hit  = o_limit_hit;
            got.pending    = o_pending_count;
            got.has_next   = o_has_next;
            got.next_due   = o_next_due;
            got.last       = o_last;
            sb.check_reply(got);
        end
        if (hold_seen != hold_seq) begin
            hold_seen  = hold_seq;
            rx_stalled = 1'b1;
            rx_left    = HOLD_CYCLES;
        end else if (rx_left <= 0) begin
            if (idling_on && $urandom_range(0, 2) == 0) begin
                rx_stalled = 1'b1;
                rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            end else begin
                rx_stalled = 1'b0;
                rx_left    = $urandom_range(1, 12);
            end
        end
        rx_left--;
        i_out_stall <= rx_stalled;
    end

    function automatic logic [TIME_BITS_DEF-1:0] rand_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_BITS_DEF-1:0];
    endfunction

    function automatic int tx_gap();
        int r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Valid stays high after the transfer; the next call or wait_for_idle settles it.
    task automatic send_item(input logic [2:0] op, input logic [TIME_BITS_DEF-1:0] tv,
                             input logic [ID_BITS_DEF-1:0] tid);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_time_value <= tv;
        i_target_id  <= tid;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.accept_command(op, tv, tid);
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.fire_limit = value;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly near-term times so events collide and runs have work to do.
    task automatic send_random_command();
        logic [2:0]               op;
        logic [TIME_BITS_DEF-1:0] tv;
        logic [TIME_BITS_DEF-1:0] now;
        logic [ID_BITS_DEF-1:0]   tid;
        int                       pick;
        int                       flavor;
        now    = sb.now_time;
        tv     = rand_time();
        tid    = $urandom;
        pick   = $urandom_range(0, 99);
        flavor = $urandom_range(0, 19);
        if (pick < 35) begin
            op = OP_SCHED_AT;
            if (flavor < 12) tv = now + 48'($urandom_range(0, 6));
            else if (flavor < 17) tv = now + 48'($urandom_range(0, 3000));
            else if (flavor == 17 && now != 0) tv = tv % now;
        end else if (pick < 55) begin
            op = OP_SCHED_AFTER;
            if (flavor < 14) tv = 48'($urandom_range(0, 6));
            else if (flavor < 18) tv = 48'($urandom_range(0, 3000));
            else if (flavor == 18 && now != 0) tv = TIME_MAX - now + 48'd1;
        end else if (pick < 67) begin
            op = OP_CANCEL;
            if (flavor < 14) tid = sb.pick_live_id();
            else if (flavor < 16) tid = '0;
            else if (flavor < 18) tid = sb.id_next - 32'($urandom_range(1, 5));
        end else if (pick < 80) begin
            op = OP_RUN_UNTIL;
            if (flavor < 16) tv = now + 48'($urandom_range(0, 12));
            else if (flavor < 18) tv = now + 48'($urandom_range(0, 65535));
            else if (now != 0) tv = tv % now;
            else tv = now;
        end else if (pick < 92) begin
            op = OP_ADVANCE_BY;
            if (flavor < 16) tv = 48'($urandom_range(0, 12));
            else if (flavor < 18) tv = 48'($urandom_range(0, 65535));
            else if (now != 0) tv = TIME_MAX - now + 48'd1;
            else tv = '0;
        end else if (pick < 97) begin
            op = OP_CLEAR;
        end else begin
            op = pick[0] ? OP_RSVD_A : OP_RSVD_B;
        end
        send_item(op, tv, tid);
    endtask

    initial begin
        sb           = new();
        i_clk        = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_CLEAR;
        i_time_value <= '0;
        i_target_id <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, each error status but full and exhausted
        send_item(OP_SCHED_AT, '0, '0);
        send_item(OP_SCHED_AT, '0, '0);
        send_item(OP_SCHED_AFTER, 48'd5, '0);
        send_item(OP_SCHED_AT, TIME_MAX, '0);
        send_item(OP_CANCEL, '0, '0);
        send_item(OP_CANCEL, '0, '1);
        send_item(OP_CANCEL, '0, 32'd4);
        send_item(OP_CANCEL, '0, 32'd4);
        send_item(OP_RUN_UNTIL, '0, '0);
        send_item(OP_ADVANCE_BY, 48'd10, '0);
        send_item(OP_SCHED_AT, 48'd3, '0);
        send_item(OP_SCHED_AFTER, TIME_MAX, '0);
        send_item(OP_RUN_UNTIL, 48'd4, '0);
        send_item(OP_ADVANCE_BY, TIME_MAX, '0);
        send_item(OP_RSVD_A, TIME_MAX, '1);
        send_item(OP_RSVD_B, TIME_MAX, '1);
        send_item(OP_SCHED_AFTER, '0, '0);
        send_item(OP_SCHED_AT, 48'd12, '0);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_CANCEL, '0, 32'd5);
        send_item(OP_ADVANCE_BY, '0, '0);
        wait_for_idle();

        // limit 0: every run stops at its first due event
        write_limit('0);
        repeat (20) send_random_command();
        wait_for_idle();

        write_limit(17'd1);
        repeat (35) send_random_command();
        wait_for_idle();

        // fill the queue while results are held back
        write_limit(17'd2);
        send_item(OP_CLEAR, '0, '0);
        hold_seq++;
        repeat (CAPACITY_DEF + 2)
            send_item(OP_SCHED_AT, sb.now_time + 48'($urandom_range(0, 3)), $urandom);
        send_item(OP_RUN_UNTIL, sb.now_time + 48'd5, '0);
        repeat (35) send_random_command();
        wait_for_idle();

        write_limit(17'($urandom_range(3, 6)));
        idling_on = 1'b0;
        repeat (35) send_random_command();
        wait_for_idle();
        idling_on = 1'b1;

        write_limit('1);
        repeat (35) send_random_command();
        // push time to the top of its range
        send_item(OP_RUN_UNTIL, TIME_MAX, '0);
        send_item(OP_SCHED_AFTER, '0, '0);
        send_item(OP_SCHED_AFTER, 48'd1, '0);
        send_item(OP_SCHED_AT, 48'd5, '0);
        send_item(OP_RUN_UNTIL, '0, '0);
        send_item(OP_ADVANCE_BY, '0, '0);
        send_item(OP_ADVANCE_BY, 48'd1, '0);
        send_item(OP_CLEAR, '0, '0);
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.replies.size() == 0) begin
            $display("timed_event_priority_queue: match");
        end else begin
            $display("timed_event_priority_queue: mismatch");
        end
        $finish;
    end
endmodule

FILE: timed_event_priority_queue.f
design/tep_pkg.sv
design/tep_cell.sv
design/timed_event_priority_queue.sv
tb/tb_timed_event_priority_queue.sv
